// ===== hw/rtl/sphere_frustum_cull_lod_defines.svh =====
// Assertion macros shared by the sphere culling RTL.
`ifndef SPHERE_FRUSTUM_CULL_LOD_DEFINES_SVH
`define SPHERE_FRUSTUM_CULL_LOD_DEFINES_SVH
`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset.
`define SFCL_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error("assertion failed");
// Condition that must never hold outside reset.
`define SFCL_NEVER(lbl, clk_s, rstn_s, expr) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
        else $error("forbidden condition");
`else
`define SFCL_ASSERT(lbl, clk_s, rstn_s, prop)
`define SFCL_NEVER(lbl, clk_s, rstn_s, expr)
`endif
`endif

// ===== hw/rtl/sfcl_pkg.sv =====
// Types and constants shared by the sphere culling block.
`timescale 1ns / 1ps
package sfcl_pkg;
    localparam int DIST_W     = 22;
    localparam int SUM_W      = 46;
    localparam int ROOT_W     = 23;
    localparam int REM_W      = 48;
    localparam int NORM_W     = 12;
    localparam int OFFS_W     = 23;
    localparam int NORM_FRAC  = 10;
    localparam int PLANE_W    = 59;
    localparam int CAM_W      = 63;
    localparam int LIMIT_W    = 22;
    localparam int LODREG_W   = 44;
    localparam int PLANE_N    = 6;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA       = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOD_LIMITS   = 4'd7;

    localparam logic [1:0] LOD_NEAR = 2'd0;
    localparam logic [1:0] LOD_MID  = 2'd1;
    localparam logic [1:0] LOD_FAR  = 2'd2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Sideband that travels with a beat through the root pipeline.
    typedef struct packed {
        logic visible;
        logic big;
    } side_t;
endpackage

// ===== hw/rtl/sfcl_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module sfcl_isqrt
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [sfcl_pkg::SUM_W-1:0]     in_sum,
    input  sfcl_pkg::side_t                in_side,
    output logic                           out_valid,
    output logic [sfcl_pkg::ROOT_W-1:0]    out_root,
    output sfcl_pkg::side_t                out_side
);
    localparam int RW = sfcl_pkg::ROOT_W;
    localparam int MW = sfcl_pkg::REM_W;

    logic            valid_reg [RW];
    logic [MW-1:0]   rem_reg   [RW];
    logic [RW-1:0]   root_reg  [RW];
    sfcl_pkg::side_t side_reg  [RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        localparam int K = RW - 1 - j;
        logic [MW-1:0]   rem_in;
        logic [RW-1:0]   root_in;
        logic            valid_in;
        sfcl_pkg::side_t side_in;
        logic [MW-1:0]   trial;
        logic [MW-1:0]   rem_next;
        logic [RW-1:0]   root_next;

        // Pick up the previous stage, or the input for the first one.
        if (j == 0) begin : g_first
            assign rem_in   = MW'(in_sum);
            assign root_in  = '0;
            assign valid_in = in_valid;
            assign side_in  = in_side;
        end
        else begin : g_rest
            assign rem_in   = rem_reg[j-1];
            assign root_in  = root_reg[j-1];
            assign valid_in = valid_reg[j-1];
            assign side_in  = side_reg[j-1];
        end

        // Try setting bit K of the root against the running remainder.
        always_comb
        begin
            trial = (MW'(root_in) << (K + 1)) | (MW'(1) << (2 * K));
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (RW'(1) << K);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else
            begin
                valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= rem_next;
            root_reg[j] <= root_next;
            side_reg[j] <= side_in;
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];
endmodule

// ===== hw/rtl/sphere_frustum_cull_lod.sv =====
// Top level of the sphere frustum culling and level-of-detail block.
`timescale 1ns / 1ps
`include "sphere_frustum_cull_lod_defines.svh"
// Usage:
// An object (pos_x, pos_y, pos_z, radius, max_height) is taken at a rising
// edge with start high and busy low. busy is always low: a new object may
// be started in every cycle, so throughput is one object per clock.
// Each object gives one result (visible, detail_level, distance), shown for
// exactly one cycle with result_valid high. The beat passes in order through
// stages A, B and C, the square root stages and the output register.
// Results leave in the order objects came in.
// The pipeline is the square root unit, which resolves one of its 23
// root bits per pipeline stage, plus three stages of plane and distance
// arithmetic and one output register.
// Configuration beats (cfg_valid, cfg_index, cfg_data) are always taken
// (cfg_ready is high); indexes above seven are ignored. Write them only
// while no object is in flight.
// Reset clears the pipeline, the planes and the camera, and loads the
// detail limits with 500.0 and 1000.0. The receiver cannot stall.
module sphere_frustum_cull_lod
#(
    parameter int COORD_WIDTH = 21,
    parameter int FRAC_BITS   = 5
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_WIDTH-1:0]       pos_x,
    input  logic signed [COORD_WIDTH-1:0]       pos_y,
    input  logic signed [COORD_WIDTH-1:0]       pos_z,
    input  logic signed [COORD_WIDTH-1:0]       radius,
    input  logic signed [COORD_WIDTH-1:0]       max_height,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sfcl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfcl_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                result_valid,
    output logic                                visible,
    output logic [1:0]                          detail_level,
    output logic [sfcl_pkg::DIST_W-1:0]         distance
);
    localparam int CW    = COORD_WIDTH;
    localparam int DW    = sfcl_pkg::DIST_W;
    localparam int NW    = sfcl_pkg::NORM_W;
    localparam int VW    = CW + 26;
    localparam int AW    = CW + 1;
    localparam int WIDEW = AW + DW;
    localparam int CEXTW = sfcl_pkg::CAM_W + 3 * CW;
    localparam int LW    = sfcl_pkg::LIMIT_W;
    localparam logic [LW-1:0] NEAR_RESET = LW'(500 << FRAC_BITS);
    localparam logic [LW-1:0] FAR_RESET  = LW'(1000 << FRAC_BITS);

    // Configuration registers.
    logic [sfcl_pkg::PLANE_W-1:0]  plane_reg [sfcl_pkg::PLANE_N];
    logic [sfcl_pkg::CAM_W-1:0]    camera_reg;
    logic [sfcl_pkg::LODREG_W-1:0] lod_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sfcl_pkg::PLANE_N; i++)
            begin
                plane_reg[i] <= '0;
            end
            camera_reg <= '0;
            lod_reg    <= {FAR_RESET, NEAR_RESET};
        end
        else if (cfg_valid)
        begin
            if (cfg_index <= sfcl_pkg::REG_PLANE_FAR)
            begin
                plane_reg[cfg_index[2:0]] <= cfg_data[sfcl_pkg::PLANE_W-1:0];
            end
            else if (cfg_index == sfcl_pkg::REG_CAMERA)
            begin
                camera_reg <= cfg_data[sfcl_pkg::CAM_W-1:0];
            end
            else if (cfg_index == sfcl_pkg::REG_LOD_LIMITS)
            begin
                lod_reg <= cfg_data[sfcl_pkg::LODREG_W-1:0];
            end
        end
    end

    // Camera fields; those lying past the register read as zero.
    logic [CEXTW-1:0]             cam_ext;
    logic signed [CW-1:0]         cam [3];
    logic signed [CW-1:0]         pos [3];
    logic signed [AW-1:0]         diff [3];
    logic [AW-1:0]                dabs [3];
    logic [WIDEW-1:0]             dwide [3];
    logic                         big_a;

    assign cam_ext = {{(3 * CW){1'b0}}, camera_reg};
    assign pos[0]  = pos_x;
    assign pos[1]  = pos_y;
    assign pos[2]  = pos_z;

    always_comb
    begin
        big_a = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            cam[i]   = $signed(cam_ext[i * CW +: CW]);
            diff[i]  = AW'(cam[i]) - AW'(pos[i]);
            dabs[i]  = diff[i][AW-1] ? AW'(-diff[i]) : AW'(diff[i]);
            dwide[i] = WIDEW'(dabs[i]);
            if (dwide[i] > WIDEW'(sfcl_pkg::DIST_MAX))
            begin
                big_a = 1'b1;
            end
        end
    end

    // Stage A: absolute differences and plane products.
    logic                 a_valid_reg;
    logic [DW-1:0]        a_dabs_reg [3];
    logic                 a_big_reg;
    logic                 a_rpos_reg;
    logic signed [VW-1:0] a_px_reg [sfcl_pkg::PLANE_N];
    logic signed [VW-1:0] a_py_reg [sfcl_pkg::PLANE_N];
    logic signed [VW-1:0] a_pz_reg [sfcl_pkg::PLANE_N];
    logic signed [VW-1:0] a_ext_reg [sfcl_pkg::PLANE_N];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_dabs_reg[i] <= dwide[i][DW-1:0];
        end
        a_big_reg  <= big_a;
        a_rpos_reg <= (radius > 0);
        for (int i = 0; i < sfcl_pkg::PLANE_N; i++)
        begin
            a_px_reg[i] <= VW'($signed(plane_reg[i][NW-1:0]) * pos_x);
            a_py_reg[i] <= VW'($signed(plane_reg[i][2*NW-1:NW]) * pos_y);
            a_pz_reg[i] <= VW'($signed(plane_reg[i][3*NW-1:2*NW]) * pos_z);
            a_ext_reg[i] <=
                VW'($signed(plane_reg[i][sfcl_pkg::PLANE_W-1:3*NW]))
                + ((i == int'(sfcl_pkg::REG_PLANE_BOTTOM)) ? VW'(max_height)
                                                            : VW'(radius));
        end
    end

    // Stage B: squares and plane values.
    logic                 b_valid_reg;
    logic [2*DW-1:0]      b_sq_reg [3];
    logic                 b_big_reg;
    logic                 b_rpos_reg;
    logic signed [VW-1:0] b_v_reg [sfcl_pkg::PLANE_N];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            b_sq_reg[i] <= (2 * DW)'(a_dabs_reg[i]) * (2 * DW)'(a_dabs_reg[i]);
        end
        b_big_reg  <= a_big_reg;
        b_rpos_reg <= a_rpos_reg;
        for (int i = 0; i < sfcl_pkg::PLANE_N; i++)
        begin
            b_v_reg[i] <= a_px_reg[i] + a_py_reg[i] + a_pz_reg[i]
                          + (a_ext_reg[i] <<< sfcl_pkg::NORM_FRAC);
        end
    end

    // Stage C: sum of squares and the visibility verdict.
    logic                        c_valid_reg;
    logic [sfcl_pkg::SUM_W-1:0]  c_sum_reg;
    sfcl_pkg::side_t             c_side_reg;
    logic                        inside_all;

    always_comb
    begin
        inside_all = 1'b1;
        for (int i = 0; i < sfcl_pkg::PLANE_N; i++)
        begin
            if (b_v_reg[i] <= 0)
            begin
                inside_all = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_sum_reg <= sfcl_pkg::SUM_W'(b_sq_reg[0]) + sfcl_pkg::SUM_W'(b_sq_reg[1])
                     + sfcl_pkg::SUM_W'(b_sq_reg[2]);
        c_side_reg.visible <= inside_all || !b_rpos_reg;
        c_side_reg.big     <= b_big_reg;
    end

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start && !busy;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Square root pipeline.
    logic                         r_valid;
    logic [sfcl_pkg::ROOT_W-1:0]  r_root;
    sfcl_pkg::side_t              r_side;

    sfcl_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid_reg),
        .in_sum    (c_sum_reg),
        .in_side   (c_side_reg),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_side  (r_side)
    );

    // Saturation and detail level.
    logic [DW-1:0] dist_sat;
    logic [1:0]    lod_next;
    logic [LW-1:0] near_lim;
    logic [LW-1:0] far_lim;

    assign near_lim = lod_reg[LW-1:0];
    assign far_lim  = lod_reg[2*LW-1:LW];

    always_comb
    begin
        if (r_side.big || (r_root > sfcl_pkg::ROOT_W'(sfcl_pkg::DIST_MAX)))
        begin
            dist_sat = sfcl_pkg::DIST_MAX;
        end
        else
        begin
            dist_sat = r_root[DW-1:0];
        end
        priority if (dist_sat < near_lim)
        begin
            lod_next = sfcl_pkg::LOD_NEAR;
        end
        else if (dist_sat < far_lim)
        begin
            lod_next = sfcl_pkg::LOD_MID;
        end
        else
        begin
            lod_next = sfcl_pkg::LOD_FAR;
        end
    end

    // Output register.
    logic          result_valid_reg;
    logic          visible_reg;
    logic [1:0]    detail_level_reg;
    logic [DW-1:0] distance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= r_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        visible_reg      <= r_side.visible;
        detail_level_reg <= lod_next;
        distance_reg     <= dist_sat;
    end

    assign result_valid = result_valid_reg;
    assign visible      = visible_reg;
    assign detail_level = detail_level_reg;
    assign distance     = distance_reg;

    // Checks.
    `SFCL_ASSERT(a_start_enters, clk, rst_n, start |=> a_valid_reg)
    `SFCL_ASSERT(a_near_lod, clk, rst_n, (result_valid && distance < near_lim) |-> (detail_level == sfcl_pkg::LOD_NEAR))
    `SFCL_ASSERT(a_big_sat, clk, rst_n, (r_valid && r_side.big) |=> (distance == sfcl_pkg::DIST_MAX))
    `SFCL_NEVER(a_bad_lod, clk, rst_n, result_valid && detail_level == 2'd3)
endmodule
